/* sv/ffc_pkg.sv */
`default_nettype none

package ffc_pkg;

  // Frame layout.
  localparam int unsigned FrameBytes = 22;
  localparam int unsigned CrcSpan    = 18;
  localparam int unsigned LastByte   = 21;
  localparam int unsigned CrcBytes   = FrameBytes - CrcSpan;
  localparam int unsigned IdxW       = 5;

  // Reflected CRC-32, all-ones start, no final inversion.
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  typedef logic [IdxW-1:0] byte_idx_t;

  // One received byte as it leaves the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } byte_item_t;

  // One decoded frame.
  typedef struct packed {
    logic               frame_ok;
    logic [7:0]         proto_rev;
    logic [7:0]         actuator_number;
    logic [7:0]         report_mode;
    logic [7:0]         fault_bits;
    logic [31:0]        seq_number;
    logic signed [15:0] measured_position;
    logic signed [15:0] measured_rate;
    logic [15:0]        motor_current;
    logic signed [15:0] temperature;
    logic [15:0]        supply_voltage;
  } result_t;

  // Byte-wide CRC update, eight shift/xor steps unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/ffc_if.sv */
`default_nettype none

interface ffc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface ffc_result_if;
  logic               valid;
  logic               ready;
  logic               frame_ok;
  logic [7:0]         proto_rev;
  logic [7:0]         actuator_number;
  logic [7:0]         report_mode;
  logic [7:0]         fault_bits;
  logic [31:0]        seq_number;
  logic signed [15:0] measured_position;
  logic signed [15:0] measured_rate;
  logic [15:0]        motor_current;
  logic signed [15:0] temperature;
  logic [15:0]        supply_voltage;

  modport source (
    output valid, output frame_ok, output proto_rev, output actuator_number,
    output report_mode, output fault_bits, output seq_number,
    output measured_position, output measured_rate, output motor_current,
    output temperature, output supply_voltage, input ready
  );
  modport sink (
    input valid, input frame_ok, input proto_rev, input actuator_number,
    input report_mode, input fault_bits, input seq_number,
    input measured_position, input measured_rate, input motor_current,
    input temperature, input supply_voltage, output ready
  );
endinterface

`default_nettype wire

/* sv/feedback_frame_checker_crc32.sv */
// Actuator feedback frame checker. Each item on frame_bytes is one byte of a
// 22-byte frame, and frame_start marks byte 0; a start in mid-frame drops the
// partial frame and begins a new one, while bytes that arrive with no frame open
// are discarded. Bytes 0 to 17 run through a reflected CRC-32 (polynomial
// 0xEDB88320, preset to all ones, no final inversion) and bytes 18 to 21 hold
// the received CRC, least significant byte first. After byte 21 the block
// delivers one item on results with the decoded header, sequence and data
// words and frame_ok; when the CRCs differ, frame_ok is low and every other
// field is zero. The block takes one byte every clock cycle while no result is
// held back, limited by the byte-wide CRC update between the input register
// and the frame state. The last byte of a frame passes the input register, and
// its result is then registered in the output register, which drives results.
// While a result waits in the output register, the byte in the input register
// waits with it, and once that register holds a byte frame_bytes.ready stays
// low, so a slow receiver holds back the byte stream.
`default_nettype none

module feedback_frame_checker_crc32 (
  input  wire logic       clk,
  input  wire logic       rst,
  ffc_byte_if.sink        frame_bytes,
  ffc_result_if.source    results
);

  // The input register releases its byte whenever the output register can
  // take whatever that byte might produce.
  logic                 advance;
  logic                 item_valid;
  ffc_pkg::byte_item_t  item;
  logic                 res_valid;
  ffc_pkg::result_t     result;

  ffc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .frame_bytes(frame_bytes),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Frame position, running CRC and captured fields live here.
  ffc_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .take     (item_valid && advance),
    .item     (item),
    .res_valid(res_valid),
    .result   (result)
  );

  ffc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .results  (results),
    .res_valid(res_valid),
    .result   (result),
    .advance  (advance)
  );

endmodule

`default_nettype wire

/* sv/ffc_in_stage.sv */
`default_nettype none

module ffc_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  ffc_byte_if.sink               frame_bytes,
  input  wire logic              advance,
  output logic                   item_valid,
  output ffc_pkg::byte_item_t    item
);

  logic                 valid;
  ffc_pkg::byte_item_t  held;

  // The register is free when empty or when its item moves on this cycle.
  assign frame_bytes.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (frame_bytes.ready) begin
      valid <= frame_bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_bytes.valid && frame_bytes.ready) begin
      held.data_byte   <= frame_bytes.data_byte;
      held.frame_start <= frame_bytes.frame_start;
    end
  end

  assign item_valid = valid;
  assign item       = held;

endmodule

`default_nettype wire

/* sv/ffc_frame.sv */
`default_nettype none

module ffc_frame (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 take,
  input  wire ffc_pkg::byte_item_t  item,
  output logic                      res_valid,
  output ffc_pkg::result_t          result
);

  ffc_pkg::byte_idx_t byte_index;
  ffc_pkg::byte_idx_t byte_index_next;
  logic [31:0]        running_crc;
  logic [31:0]        running_crc_next;

  // Bytes 0..17 and the first three trailer bytes; written once per frame.
  logic [7:0] field_byte [ffc_pkg::CrcSpan];
  logic [7:0] trailer    [ffc_pkg::CrcBytes-1];

  ffc_pkg::byte_idx_t idx;
  logic               active;
  logic               last;
  logic [31:0]        crc_in;
  logic [31:0]        rx_crc;
  logic               ok;
  logic [1:0]         trl_sel;

  always_comb begin
    idx    = item.frame_start ? '0 : byte_index;
    active = take && (item.frame_start || (byte_index < ffc_pkg::IdxW'(ffc_pkg::FrameBytes)));
    last   = active && (idx == ffc_pkg::IdxW'(ffc_pkg::LastByte));
    crc_in = item.frame_start ? ffc_pkg::CrcInit : running_crc;

    if (idx < ffc_pkg::IdxW'(ffc_pkg::CrcSpan)) begin
      running_crc_next = ffc_pkg::crc_byte(crc_in, item.data_byte);
    end else begin
      running_crc_next = crc_in;
    end

    if (last) begin
      byte_index_next = ffc_pkg::IdxW'(ffc_pkg::FrameBytes);
    end else begin
      byte_index_next = idx + 1'b1;
    end

    trl_sel = 2'(idx - ffc_pkg::IdxW'(ffc_pkg::CrcSpan));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= ffc_pkg::IdxW'(ffc_pkg::FrameBytes);
      running_crc <= ffc_pkg::CrcInit;
    end else if (active) begin
      byte_index  <= byte_index_next;
      running_crc <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      if (idx < ffc_pkg::IdxW'(ffc_pkg::CrcSpan)) begin
        field_byte[idx] <= item.data_byte;
      end else if (!last) begin
        trailer[trl_sel] <= item.data_byte;
      end
    end
  end

  // The last trailer byte is the one arriving now; the CRC is final after byte 17.
  assign rx_crc = {item.data_byte, trailer[2], trailer[1], trailer[0]};
  assign ok     = (running_crc == rx_crc);

  always_comb begin
    result = '0;
    if (ok) begin
      result.frame_ok          = 1'b1;
      result.proto_rev         = field_byte[0];
      result.actuator_number   = field_byte[1];
      result.report_mode       = field_byte[2];
      result.fault_bits        = field_byte[3];
      result.seq_number        = {field_byte[7], field_byte[6], field_byte[5], field_byte[4]};
      result.measured_position = $signed({field_byte[9], field_byte[8]});
      result.measured_rate     = $signed({field_byte[11], field_byte[10]});
      result.motor_current     = {field_byte[13], field_byte[12]};
      result.temperature       = $signed({field_byte[15], field_byte[14]});
      result.supply_voltage    = {field_byte[17], field_byte[16]};
    end
  end

  assign res_valid = last;

`ifndef SYNTH
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= ffc_pkg::IdxW'(ffc_pkg::FrameBytes))
    else $error("frame position out of range");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (byte_index == ffc_pkg::IdxW'(ffc_pkg::FrameBytes)))
    else $error("block not idle after a completed frame");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.frame_ok) |-> (result.seq_number == 32'd0 &&
      result.proto_rev == 8'd0 && result.supply_voltage == 16'd0))
    else $error("failed frame carries nonzero fields");

  a_step: assert property (@(posedge clk) disable iff (rst)
    (active && !last) |=> (byte_index == $past(idx) + 1'b1))
    else $error("frame position did not advance by one");
`endif

endmodule

`default_nettype wire

/* sv/ffc_out_stage.sv */
`default_nettype none

module ffc_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  ffc_result_if.source           results,
  input  wire logic              res_valid,
  input  wire ffc_pkg::result_t  result,
  output logic                   advance
);

  logic             valid;
  ffc_pkg::result_t held;

  assign advance = !valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      held <= result;
    end
  end

  assign results.valid             = valid;
  assign results.frame_ok          = held.frame_ok;
  assign results.proto_rev         = held.proto_rev;
  assign results.actuator_number   = held.actuator_number;
  assign results.report_mode       = held.report_mode;
  assign results.fault_bits        = held.fault_bits;
  assign results.seq_number        = held.seq_number;
  assign results.measured_position = held.measured_position;
  assign results.measured_rate     = held.measured_rate;
  assign results.motor_current     = held.motor_current;
  assign results.temperature       = held.temperature;
  assign results.supply_voltage    = held.supply_voltage;

endmodule

`default_nettype wire

/* sim/tb_feedback_frame_checker_crc32.sv */
`timescale 1ns / 1ps

module tb_feedback_frame_checker_crc32;

  // One row of the directed table is one frame. The 18 body bytes are packed
  // with byte 0 in bits 7:0, so each field literal is already little-endian.
  typedef struct packed {
    logic [ffc_pkg::CrcSpan*8-1:0] body;
    logic [31:0]          trailer;   // used as given unless seal is set
    logic                 seal;      // replace the trailer with the body's CRC
    logic [4:0]           cut;       // bytes of an aborted frame sent first
    logic [2:0]           stray;     // bytes without a start flag sent first
    logic                 pinned;    // expected result typed into the row
    ffc_pkg::result_t     pin;
  } frame_row_t;

  // Directed frames. The only rows whose result is typed in are the ones
  // where the answer is obvious: an all-zero body with an all-zero trailer
  // cannot pass, because the CRC register starts at all ones and a zero byte
  // only moves it through an invertible map, so it never reaches zero.
  localparam frame_row_t DirectedFrames [9] = '{
    // Failed check: every result field must read zero.
    '{{ffc_pkg::CrcSpan{8'h00}}, 32'h0000_0000, 1'b0, 5'd0, 3'd0, 1'b1, '0},
    // Smallest field values with a correct trailer.
    '{{ffc_pkg::CrcSpan{8'h00}}, 32'h0000_0000, 1'b1, 5'd0, 3'd0, 1'b0, '0},
    // Largest byte everywhere: all signed fields read -1.
    '{{ffc_pkg::CrcSpan{8'hFF}}, 32'h0000_0000, 1'b1, 5'd0, 3'd0, 1'b0, '0},
    // Signed extremes on both ends, sequence word with only its end bits set.
    '{{16'h0000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF, 32'h8000_0001,
       8'h80, 8'h7F, 8'h01, 8'hFE}, 32'h0000_0000, 1'b1, 5'd0, 3'd0, 1'b0, '0},
    // Start flag in mid-frame: nine bytes are dropped and the frame restarts.
    '{{16'h1234, 16'h8001, 16'h00FF, 16'h7FFE, 16'hC350, 32'hDEAD_BEEF,
       8'h5A, 8'hA5, 8'h3C, 8'hC3}, 32'h0000_0000, 1'b1, 5'd9, 3'd0, 1'b0, '0},
    // Bytes while idle after a complete frame are thrown away.
    '{{16'hFFFE, 16'h0001, 16'hABCD, 16'hFF00, 16'h00FF, 32'h0102_0304,
       8'h10, 8'h20, 8'h40, 8'h80}, 32'h0000_0000, 1'b1, 5'd0, 3'd3, 1'b0, '0},
    // Restart that lands exactly where the last byte would have been.
    '{{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 32'hAAAA_5555,
       8'h01, 8'h02, 8'h04, 8'h08}, 32'h0000_0000, 1'b1, 5'd21, 3'd0, 1'b0, '0},
    // Wrong trailers on nonzero bodies; checked against the predictor.
    '{{16'h0000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF, 32'h8000_0001,
       8'h80, 8'h7F, 8'h01, 8'hFE}, 32'hDEAD_BEEF, 1'b0, 5'd0, 3'd0, 1'b0, '0},
    '{{ffc_pkg::CrcSpan{8'hFF}}, 32'hFFFF_FFFF, 1'b0, 5'd0, 3'd0, 1'b0, '0}
  };

  localparam int BytesPerPhase = 520;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffc_byte_if   byte_ch ();
  ffc_result_if result_ch ();

  feedback_frame_checker_crc32 uut (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (byte_ch),
    .results     (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Chance in percent that the sender holds back a byte or the receiver
  // refuses a result on a given cycle.
  int unsigned src_idle_pct  = 6;
  int unsigned sink_stall_pct = 69;

  // A typed expectation rides along with the byte that finishes its frame.
  logic             pin_on = 1'b0;
  ffc_pkg::result_t pin_val = '0;

  // Predictor state: where the next byte lands, the running CRC and the
  // fields captured so far.
  ffc_pkg::byte_idx_t next_pos = ffc_pkg::byte_idx_t'(ffc_pkg::FrameBytes);
  logic [31:0] crc_run = ffc_pkg::CrcInit;
  logic [7:0]  hdr_byte [4];
  logic [31:0] seq_word;
  logic [15:0] data_word [5];
  logic [31:0] rx_trailer;

  ffc_pkg::result_t decoded_frames [$];

  int mismatch_count = 0;
  int results_seen = 0;
  int frames_good = 0;
  int bytes_sent = 0;
  int frames_sent = 0;

  // Reflected CRC-32, one data bit at a time, least significant bit first.
  function automatic logic [31:0] crc_advance(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ ffc_pkg::CrcPoly;
    end
    return r;
  endfunction

  function automatic logic [31:0] body_crc(input logic [ffc_pkg::CrcSpan*8-1:0] body);
    logic [31:0] c;
    c = ffc_pkg::CrcInit;
    for (int i = 0; i < ffc_pkg::CrcSpan; i++) c = crc_advance(c, body[8*i +: 8]);
    return c;
  endfunction

  // Feeds one accepted byte through the predictor. Returns 1 when the byte
  // closes a frame, with the decoded result in r.
  function automatic bit absorb_byte(input logic [7:0] b, input logic s,
                                     output ffc_pkg::result_t r);
    r = '0;
    if (s) begin
      next_pos = '0;
      crc_run  = ffc_pkg::CrcInit;
    end else if (next_pos >= ffc_pkg::FrameBytes) begin
      return 1'b0;
    end

    if (next_pos < 4) begin
      hdr_byte[next_pos] = b;
    end else if (next_pos < 8) begin
      seq_word[(next_pos - 4) * 8 +: 8] = b;
    end else if (next_pos < ffc_pkg::CrcSpan) begin
      if (next_pos[0]) data_word[(next_pos - 8) / 2][15:8] = b;
      else data_word[(next_pos - 8) / 2][7:0] = b;
    end else begin
      rx_trailer[(next_pos - ffc_pkg::CrcSpan) * 8 +: 8] = b;
    end

    if (next_pos < ffc_pkg::CrcSpan) crc_run = crc_advance(crc_run, b);

    if (next_pos != ffc_pkg::LastByte) begin
      next_pos = next_pos + 1'b1;
      return 1'b0;
    end

    next_pos = ffc_pkg::byte_idx_t'(ffc_pkg::FrameBytes);
    if (crc_run == rx_trailer) begin
      r.frame_ok          = 1'b1;
      r.proto_rev         = hdr_byte[0];
      r.actuator_number   = hdr_byte[1];
      r.report_mode       = hdr_byte[2];
      r.fault_bits        = hdr_byte[3];
      r.seq_number        = seq_word;
      r.measured_position = data_word[0];
      r.measured_rate     = data_word[1];
      r.motor_current     = data_word[2];
      r.temperature       = data_word[3];
      r.supply_voltage    = data_word[4];
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] result %0d mismatch: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  // Every accepted byte goes through the predictor; a closing byte leaves
  // its expected result in the queue, or the typed one if the row has one.
  always @(posedge clk) begin : byte_monitor
    ffc_pkg::result_t r;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      if (absorb_byte(byte_ch.data_byte, byte_ch.frame_start, r)) begin
        if (pin_on) r = pin_val;
        decoded_frames.push_back(r);
      end
    end
  end

  // Each accepted result is held against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    ffc_pkg::result_t got;
    ffc_pkg::result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.frame_ok          = result_ch.frame_ok;
      got.proto_rev         = result_ch.proto_rev;
      got.actuator_number   = result_ch.actuator_number;
      got.report_mode       = result_ch.report_mode;
      got.fault_bits        = result_ch.fault_bits;
      got.seq_number        = result_ch.seq_number;
      got.measured_position = result_ch.measured_position;
      got.measured_rate     = result_ch.measured_rate;
      got.motor_current     = result_ch.motor_current;
      got.temperature       = result_ch.temperature;
      got.supply_voltage    = result_ch.supply_voltage;
      if (decoded_frames.size() == 0) begin
        flag_mismatch("result arrived with no frame pending");
      end else begin
        want = decoded_frames.pop_front();
        check_field("frame_ok", got.frame_ok, want.frame_ok);
        check_field("proto_rev", got.proto_rev, want.proto_rev);
        check_field("actuator_number", got.actuator_number, want.actuator_number);
        check_field("report_mode", got.report_mode, want.report_mode);
        check_field("fault_bits", got.fault_bits, want.fault_bits);
        check_field("seq_number", got.seq_number, want.seq_number);
        check_field("measured_position", got.measured_position, want.measured_position);
        check_field("measured_rate", got.measured_rate, want.measured_rate);
        check_field("motor_current", got.motor_current, want.motor_current);
        check_field("temperature", got.temperature, want.temperature);
        check_field("supply_voltage", got.supply_voltage, want.supply_voltage);
        if (got.frame_ok) frames_good++;
      end
      results_seen++;
    end
  end

  // The receiver refuses results at random, at the rate of the current phase.
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Offers one byte, after a random number of idle cycles, and returns on the
  // edge that accepts it. While idle the payload carries junk.
  task automatic put_byte(input logic [7:0] b, input logic s, input logic pin,
                          input ffc_pkg::result_t pv);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid       <= 1'b0;
      byte_ch.data_byte   <= 8'($urandom);
      byte_ch.frame_start <= 1'($urandom);
      @(posedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b;
    byte_ch.frame_start <= s;
    pin_on              <= pin;
    pin_val             <= pv;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  // Sends the first nbytes of a frame, with the start flag on byte 0.
  task automatic send_frame(input logic [ffc_pkg::CrcSpan*8-1:0] body,
                            input logic [31:0] trailer, input int nbytes,
                            input logic pinned, input ffc_pkg::result_t pin);
    logic [7:0] fr [ffc_pkg::FrameBytes];
    for (int i = 0; i < ffc_pkg::CrcSpan; i++) fr[i] = body[8*i +: 8];
    for (int i = 0; i < 4; i++) fr[ffc_pkg::CrcSpan + i] = trailer[8*i +: 8];
    for (int i = 0; i < nbytes; i++) begin
      put_byte(fr[i], i == 0, pinned && i == ffc_pkg::LastByte, pin);
    end
    bytes_sent += nbytes;
    if (nbytes == ffc_pkg::FrameBytes) frames_sent++;
  endtask

  // Bytes with no start flag. After a complete frame the block ignores them;
  // after a cut-off frame they carry on where it stopped.
  task automatic send_strays(input int n);
    repeat (n) put_byte(8'($urandom), 1'b0, 1'b0, '0);
  endtask

  // Random body that leans toward the byte values at the field boundaries.
  function automatic logic [ffc_pkg::CrcSpan*8-1:0] random_body();
    logic [ffc_pkg::CrcSpan*8-1:0] body;
    for (int i = 0; i < ffc_pkg::CrcSpan; i++) begin
      case ($urandom_range(7))
        0: body[8*i +: 8] = 8'h00;
        1: body[8*i +: 8] = 8'hFF;
        2: body[8*i +: 8] = 8'h7F;
        3: body[8*i +: 8] = 8'h80;
        default: body[8*i +: 8] = 8'($urandom);
      endcase
    end
    return body;
  endfunction

  initial begin : stimulus
    frame_row_t                    row;
    logic [ffc_pkg::CrcSpan*8-1:0] body;
    logic [31:0]                   trailer;
    int unsigned                   pick;

    // Every input is known from time zero.
    byte_ch.valid       = 1'b0;
    byte_ch.data_byte   = 8'h00;
    byte_ch.frame_start = 1'b0;
    result_ch.ready     = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames run under the first idling pattern.
    foreach (DirectedFrames[i]) begin
      row = DirectedFrames[i];
      trailer = row.seal ? body_crc(row.body) : row.trailer;
      send_strays(row.stray);
      if (row.cut != 0) send_frame(row.body, trailer, row.cut, 1'b0, '0);
      send_frame(row.body, trailer, ffc_pkg::FrameBytes, row.pinned, row.pin);
    end

    // Random frames in three phases: a slow receiver, then a slow sender,
    // then both at full speed. Most frames are well formed so that the CRC
    // compare and the field capture get exercised; the rest carry a damaged
    // trailer or body or get cut off by a new start, and any frame may be followed by noise.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 6;
          sink_stall_pct = 69;
        end
        1: begin
          src_idle_pct   = 69;
          sink_stall_pct = 6;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      while (bytes_sent < BytesPerPhase * (phase + 1)) begin
        body    = random_body();
        trailer = body_crc(body);
        pick    = $urandom_range(99);
        if (pick < 12) begin
          trailer = trailer ^ (32'h1 << $urandom_range(31));
        end else if (pick < 18) begin
          body[$urandom_range(ffc_pkg::CrcSpan*8-1)] ^= 1'b1;
        end
        if (pick >= 18 && pick < 28) begin
          send_frame(body, trailer, $urandom_range(1, ffc_pkg::LastByte), 1'b0, '0);
        end else begin
          send_frame(body, trailer, ffc_pkg::FrameBytes, 1'b0, '0);
        end
        if ($urandom_range(9) == 0) send_strays($urandom_range(1, 4));
      end
    end

    byte_ch.valid <= 1'b0;

    // Drain, then give a stray extra result time to show up.
    while (decoded_frames.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d frame bytes forming %0d complete frames, with restarts and idle noise.",
             bytes_sent, frames_sent);
    $display("Checked %0d results: %0d passed the CRC compare, %0d were rejected.",
             results_seen, frames_good, results_seen - frames_good);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d results still pending.", decoded_frames.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
